// ----- src/tick_task_scheduler_top_defines.svh -----
// Assertion helpers shared by the scheduler RTL.
`ifndef TICK_TASK_SCHEDULER_TOP_DEFINES_SVH
`define TICK_TASK_SCHEDULER_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define TTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at the same clock edge.
`define TTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/tts_pkg.sv -----
package tts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int HIGH_DEPTH_DEF = 8;
  localparam int NORM_DEPTH_DEF = 8;
  localparam int LOW_DEPTH_DEF  = 8;

  localparam int ID_W    = 8;
  localparam int DLY_W   = 16;
  localparam int PRIO_W  = 2;
  localparam int REQ_W   = 3;
  localparam int UPT_W   = 64;
  localparam int STAT_W  = 2;
  localparam int IN_DATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_TASK = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD_CALL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SET_STATE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DISPATCH = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_NORM = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_LOW  = 2'd2;

endpackage

// ----- src/tts_ram.sv -----
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/tick_task_scheduler_top.sv -----
// Tick-driven priority task scheduler. One request is taken at a time and
// gives one result. Tick, add task, remove task and set state walk the task
// table one slot per cycle through a single compare/update unit between the
// start and response states; a tick with the timer off and an add task with
// id zero skip the walk, and an overflow during a tick ends the walk at the
// overflowing slot. Add call, dispatch, skipped walks and undefined requests
// go from the start state straight to the response state. The table is
// rotated through slot 0 during the walk, so it keeps its order. Ready ids
// sit in three RAM-based FIFOs with a registered read.
// A new request is accepted as soon as the previous result is in the output
// register, even if it has not been taken yet.
`include "tick_task_scheduler_top_defines.svh"

module tick_task_scheduler_top #(
  parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEF,
  parameter int HIGH_DEPTH = tts_pkg::HIGH_DEPTH_DEF,
  parameter int NORM_DEPTH = tts_pkg::NORM_DEPTH_DEF,
  parameter int LOW_DEPTH  = tts_pkg::LOW_DEPTH_DEF,
  localparam int CW = $clog2(TASK_SLOTS + 1),
  localparam int OW = tts_pkg::STAT_W + tts_pkg::ID_W + 1 + CW + tts_pkg::UPT_W,
  localparam int OB = ((OW + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,   // timer_enable
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // req_type[2:0], task_id[10:3], delay_ticks[26:11], prio[28:27],
  // repeating[29], active[30]
  input  logic [tts_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status, dispatched_id, dispatch_valid, task_count, uptime
  output logic [OB-1:0]                  out_tdata
);

  localparam int MAXD = (HIGH_DEPTH > NORM_DEPTH) ?
                        ((HIGH_DEPTH > LOW_DEPTH) ? HIGH_DEPTH : LOW_DEPTH) :
                        ((NORM_DEPTH > LOW_DEPTH) ? NORM_DEPTH : LOW_DEPTH);
  localparam int PW = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int FW = $clog2(MAXD + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [tts_pkg::REQ_W-1:0]  rq_type_r, rq_type_nxt;
  logic [tts_pkg::ID_W-1:0]   rq_id_r, rq_id_nxt;
  logic [tts_pkg::DLY_W-1:0]  rq_dly_r, rq_dly_nxt;
  logic [tts_pkg::PRIO_W-1:0] rq_prio_r, rq_prio_nxt;
  logic                       rq_rep_r, rq_rep_nxt;
  logic                       rq_act_r, rq_act_nxt;

  logic [tts_pkg::ID_W-1:0]   sid_r [TASK_SLOTS];
  logic [tts_pkg::ID_W-1:0]   sid_nxt [TASK_SLOTS];
  logic [tts_pkg::DLY_W-1:0]  scd_r [TASK_SLOTS];
  logic [tts_pkg::DLY_W-1:0]  scd_nxt [TASK_SLOTS];
  logic [tts_pkg::DLY_W-1:0]  sper_r [TASK_SLOTS];
  logic [tts_pkg::DLY_W-1:0]  sper_nxt [TASK_SLOTS];
  logic [tts_pkg::PRIO_W-1:0] spri_r [TASK_SLOTS];
  logic [tts_pkg::PRIO_W-1:0] spri_nxt [TASK_SLOTS];
  logic                       sact_r [TASK_SLOTS];
  logic                       sact_nxt [TASK_SLOTS];

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          found_r, found_nxt;
  logic [tts_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [1:0]    dsel_r, dsel_nxt;
  logic          dvalid_r, dvalid_nxt;

  logic [FW-1:0] fill_r [3];
  logic [FW-1:0] fill_nxt [3];
  logic [PW-1:0] wptr_r [3];
  logic [PW-1:0] wptr_nxt [3];
  logic [PW-1:0] rptr_r [3];
  logic [PW-1:0] rptr_nxt [3];
  logic [FW-1:0] fdepth [3];
  logic          ram_we [3];
  logic          ram_re [3];
  logic [tts_pkg::ID_W-1:0] ram_rdata [3];

  logic [tts_pkg::UPT_W-1:0] uptime_r, uptime_nxt;
  logic ten_r;
  logic out_valid_r, out_valid_nxt;
  logic [OB-1:0] out_data_r, out_data_nxt;

  // shared push unit
  logic push_en;
  logic [tts_pkg::ID_W-1:0] push_id;
  logic [tts_pkg::PRIO_W-1:0] push_prio;
  logic push_full;

  // head-of-table update
  logic [tts_pkg::ID_W-1:0]   h_id;
  logic [tts_pkg::DLY_W-1:0]  h_cd, h_per;
  logic [tts_pkg::PRIO_W-1:0] h_pri;
  logic                       h_act;
  logic                       h_rm;

  assign fdepth[0] = FW'(HIGH_DEPTH);
  assign fdepth[1] = FW'(NORM_DEPTH);
  assign fdepth[2] = FW'(LOW_DEPTH);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    push_full = 1'b0;
    for (int p = 0; p < 3; p++) begin
      ram_we[p] = 1'b0;
      if (push_en && push_prio == 2'(p)) begin
        if (fill_r[p] >= fdepth[p]) begin
          push_full = 1'b1;
        end else begin
          ram_we[p] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic any_rm;
    logic do_clear;
    logic do_append;
    logic do_shift;
    any_rm    = 1'b0;
    do_clear  = 1'b0;
    do_append = 1'b0;
    do_shift  = 1'b0;

    state_nxt   = state_r;
    rq_type_nxt = rq_type_r;
    rq_id_nxt   = rq_id_r;
    rq_dly_nxt  = rq_dly_r;
    rq_prio_nxt = rq_prio_r;
    rq_rep_nxt  = rq_rep_r;
    rq_act_nxt  = rq_act_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    dsel_nxt    = dsel_r;
    dvalid_nxt  = dvalid_r;
    uptime_nxt  = uptime_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    push_en   = 1'b0;
    push_id   = rq_id_r;
    push_prio = rq_prio_r;
    for (int p = 0; p < 3; p++) begin
      fill_nxt[p] = fill_r[p];
      wptr_nxt[p] = wptr_r[p];
      rptr_nxt[p] = rptr_r[p];
      ram_re[p]   = 1'b0;
    end
    for (int j = 0; j < TASK_SLOTS; j++) begin
      sid_nxt[j]  = sid_r[j];
      scd_nxt[j]  = scd_r[j];
      sper_nxt[j] = sper_r[j];
      spri_nxt[j] = spri_r[j];
      sact_nxt[j] = sact_r[j];
    end

    h_id  = sid_r[0];
    h_cd  = scd_r[0];
    h_per = sper_r[0];
    h_pri = spri_r[0];
    h_act = sact_r[0];
    h_rm  = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rq_type_nxt = in_tdata[2:0];
          rq_id_nxt   = in_tdata[10:3];
          rq_dly_nxt  = in_tdata[26:11];
          rq_prio_nxt = in_tdata[28:27];
          rq_rep_nxt  = in_tdata[29];
          rq_act_nxt  = in_tdata[30];
          state_nxt   = S_START;
        end
      end

      S_START: begin
        status_nxt = tts_pkg::ST_OK;
        dvalid_nxt = 1'b0;
        found_nxt  = 1'b0;
        n_nxt      = cnt_r;
        state_nxt  = S_RESP;
        case (rq_type_r)
          tts_pkg::REQ_TICK: begin
            if (ten_r) begin
              state_nxt = S_WALK;
            end
          end
          tts_pkg::REQ_ADD_TASK: begin
            if (rq_id_r != '0) begin
              state_nxt = S_WALK;
            end
          end
          tts_pkg::REQ_ADD_CALL: begin
            if (rq_id_r != '0 && rq_prio_r != 2'd3) begin
              push_en = 1'b1;
              if (push_full) begin
                do_clear   = 1'b1;
                status_nxt = tts_pkg::ST_OVERFLOW;
              end
            end
          end
          tts_pkg::REQ_REMOVE, tts_pkg::REQ_SET_STATE: begin
            state_nxt = S_WALK;
          end
          tts_pkg::REQ_DISPATCH: begin
            if (fill_r[0] != '0) begin
              dsel_nxt = 2'd0;
              dvalid_nxt = 1'b1;
            end else if (fill_r[1] != '0) begin
              dsel_nxt = 2'd1;
              dvalid_nxt = 1'b1;
            end else if (fill_r[2] != '0) begin
              dsel_nxt = 2'd2;
              dvalid_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
        // pop the selected FIFO
        for (int p = 0; p < 3; p++) begin
          if (rq_type_r == tts_pkg::REQ_DISPATCH && dvalid_nxt && dsel_nxt == 2'(p)) begin
            ram_re[p]   = 1'b1;
            fill_nxt[p] = fill_r[p] - FW'(1);
            rptr_nxt[p] = (rptr_r[p] == PW'(fdepth[p] - FW'(1))) ? '0 : rptr_r[p] + PW'(1);
          end
        end
      end

      S_WALK: begin
        if (n_r == '0) begin
          state_nxt = S_RESP;
          case (rq_type_r)
            tts_pkg::REQ_TICK: begin
              uptime_nxt = uptime_r + 64'd1;
            end
            tts_pkg::REQ_ADD_TASK: begin
              if (!found_r) begin
                if (cnt_r < CW'(TASK_SLOTS)) begin
                  do_append = 1'b1;
                  cnt_nxt   = cnt_r + CW'(1);
                end else begin
                  do_clear   = 1'b1;
                  status_nxt = tts_pkg::ST_OVERFLOW;
                end
              end
            end
            default: begin
              if (!found_r) begin
                status_nxt = tts_pkg::ST_NOT_FOUND;
              end
            end
          endcase
        end else begin
          do_shift = 1'b1;
          n_nxt    = n_r - CW'(1);
          case (rq_type_r)
            tts_pkg::REQ_TICK: begin
              if (sact_r[0]) begin
                if (scd_r[0] != '0) begin
                  h_cd = scd_r[0] - 16'd1;
                end else begin
                  push_en   = (spri_r[0] != 2'd3);
                  push_id   = sid_r[0];
                  push_prio = spri_r[0];
                  if (push_full) begin
                    // overflow stops the walk; the tick still counts
                    do_shift   = 1'b0;
                    do_clear   = 1'b1;
                    status_nxt = tts_pkg::ST_OVERFLOW;
                    uptime_nxt = uptime_r + 64'd1;
                    state_nxt  = S_RESP;
                  end else if (sper_r[0] == '0) begin
                    h_rm = 1'b1;
                  end else begin
                    h_cd = sper_r[0];
                  end
                end
              end
            end
            default: begin
              if (sid_r[0] == rq_id_r) begin
                found_nxt = 1'b1;
                case (rq_type_r)
                  tts_pkg::REQ_ADD_TASK: begin
                    h_per = rq_rep_r ? rq_dly_r : '0;
                    h_pri = rq_prio_r;
                    h_act = rq_act_r;
                  end
                  tts_pkg::REQ_REMOVE: begin
                    h_rm = 1'b1;
                  end
                  default: begin
                    h_act = rq_act_r;
                  end
                endcase
              end
            end
          endcase
          any_rm = do_shift && h_rm;
          if (any_rm) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[OW-1:0] = {uptime_r, cnt_r, dvalid_r,
                                  dvalid_r ? ram_rdata[dsel_r] : 8'd0, status_r};
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // table lanes: rotate through slot 0, processed head goes to the back
    if (do_shift) begin
      for (int j = 0; j < TASK_SLOTS; j++) begin
        if (CW'(j + 1) == cnt_r && !h_rm) begin
          sid_nxt[j]  = h_id;
          scd_nxt[j]  = h_cd;
          sper_nxt[j] = h_per;
          spri_nxt[j] = h_pri;
          sact_nxt[j] = h_act;
        end else if (j < TASK_SLOTS - 1) begin
          sid_nxt[j]  = sid_r[(j + 1) % TASK_SLOTS];
          scd_nxt[j]  = scd_r[(j + 1) % TASK_SLOTS];
          sper_nxt[j] = sper_r[(j + 1) % TASK_SLOTS];
          spri_nxt[j] = spri_r[(j + 1) % TASK_SLOTS];
          sact_nxt[j] = sact_r[(j + 1) % TASK_SLOTS];
        end
      end
    end

    if (do_append) begin
      for (int j = 0; j < TASK_SLOTS; j++) begin
        if (CW'(j) == cnt_r) begin
          sid_nxt[j]  = rq_id_r;
          scd_nxt[j]  = rq_dly_r;
          sper_nxt[j] = rq_rep_r ? rq_dly_r : '0;
          spri_nxt[j] = rq_prio_r;
          sact_nxt[j] = rq_act_r;
        end
      end
    end

    for (int p = 0; p < 3; p++) begin
      if (ram_we[p]) begin
        fill_nxt[p] = fill_r[p] + FW'(1);
        wptr_nxt[p] = (wptr_r[p] == PW'(fdepth[p] - FW'(1))) ? '0 : wptr_r[p] + PW'(1);
      end
    end

    if (do_clear) begin
      cnt_nxt = '0;
      for (int p = 0; p < 3; p++) begin
        fill_nxt[p] = '0;
        wptr_nxt[p] = '0;
        rptr_nxt[p] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      found_r     <= 1'b0;
      status_r    <= tts_pkg::ST_OK;
      dsel_r      <= 2'd0;
      dvalid_r    <= 1'b0;
      uptime_r    <= '0;
      ten_r       <= 1'b1;
      out_valid_r <= 1'b0;
      for (int p = 0; p < 3; p++) begin
        fill_r[p] <= '0;
        wptr_r[p] <= '0;
        rptr_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      found_r     <= found_nxt;
      status_r    <= status_nxt;
      dsel_r      <= dsel_nxt;
      dvalid_r    <= dvalid_nxt;
      uptime_r    <= uptime_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ten_r <= cfg_wr_data;
      end
      for (int p = 0; p < 3; p++) begin
        fill_r[p] <= fill_nxt[p];
        wptr_r[p] <= wptr_nxt[p];
        rptr_r[p] <= rptr_nxt[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    rq_type_r  <= rq_type_nxt;
    rq_id_r    <= rq_id_nxt;
    rq_dly_r   <= rq_dly_nxt;
    rq_prio_r  <= rq_prio_nxt;
    rq_rep_r   <= rq_rep_nxt;
    rq_act_r   <= rq_act_nxt;
    out_data_r <= out_data_nxt;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      sid_r[j]  <= sid_nxt[j];
      scd_r[j]  <= scd_nxt[j];
      sper_r[j] <= sper_nxt[j];
      spri_r[j] <= spri_nxt[j];
      sact_r[j] <= sact_nxt[j];
    end
  end

  tts_ram #(.WIDTH(tts_pkg::ID_W), .DEPTH(HIGH_DEPTH)) u_high_fifo (
    .clk   (clk),
    .we    (ram_we[0]),
    .waddr (wptr_r[0][(HIGH_DEPTH > 1 ? $clog2(HIGH_DEPTH) : 1)-1:0]),
    .wdata (push_id),
    .re    (ram_re[0]),
    .raddr (rptr_r[0][(HIGH_DEPTH > 1 ? $clog2(HIGH_DEPTH) : 1)-1:0]),
    .rdata (ram_rdata[0])
  );

  tts_ram #(.WIDTH(tts_pkg::ID_W), .DEPTH(NORM_DEPTH)) u_norm_fifo (
    .clk   (clk),
    .we    (ram_we[1]),
    .waddr (wptr_r[1][(NORM_DEPTH > 1 ? $clog2(NORM_DEPTH) : 1)-1:0]),
    .wdata (push_id),
    .re    (ram_re[1]),
    .raddr (rptr_r[1][(NORM_DEPTH > 1 ? $clog2(NORM_DEPTH) : 1)-1:0]),
    .rdata (ram_rdata[1])
  );

  tts_ram #(.WIDTH(tts_pkg::ID_W), .DEPTH(LOW_DEPTH)) u_low_fifo (
    .clk   (clk),
    .we    (ram_we[2]),
    .waddr (wptr_r[2][(LOW_DEPTH > 1 ? $clog2(LOW_DEPTH) : 1)-1:0]),
    .wdata (push_id),
    .re    (ram_re[2]),
    .raddr (rptr_r[2][(LOW_DEPTH > 1 ? $clog2(LOW_DEPTH) : 1)-1:0]),
    .rdata (ram_rdata[2])
  );

  `TTS_ASSERT(a_cnt_max, cnt_r <= CW'(TASK_SLOTS), "task table count above capacity")
  `TTS_ASSERT_IMP(a_walk_left, state_r == S_WALK, n_r <= cnt_r, "walk longer than table")
  `TTS_ASSERT(a_high_fill, fill_r[0] <= fdepth[0], "high FIFO fill above depth")
  `TTS_ASSERT(a_norm_fill, fill_r[1] <= fdepth[1], "normal FIFO fill above depth")
  `TTS_ASSERT(a_low_fill, fill_r[2] <= fdepth[2], "low FIFO fill above depth")

endmodule
